// ===== hw/rtl/stc_pkg.sv =====
// Shared constants and types of the self-organizing map train/classify core.
package stc_pkg;

  localparam int MAP_WIDTH_DEF  = 8;
  localparam int MAP_HEIGHT_DEF = 8;
  localparam int FEATURES_DEF   = 8;

  localparam int NUM_REGS = 8;
  localparam int REG_W    = 16;
  localparam int IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS_A_START = 3'd0,
    REG_RADIUS_A_END   = 3'd1,
    REG_RATE_A_START   = 3'd2,
    REG_RATE_A_END     = 3'd3,
    REG_RADIUS_B_START = 3'd4,
    REG_RADIUS_B_END   = 3'd5,
    REG_RATE_B_START   = 3'd6,
    REG_RATE_B_END     = 3'd7
  } reg_idx_t;

  localparam logic [REG_W-1:0] RADIUS_A_START_RST = 16'd1365;
  localparam logic [REG_W-1:0] RADIUS_A_END_RST   = 16'd26;
  localparam logic [REG_W-1:0] RATE_A_START_RST   = 16'd9830;
  localparam logic [REG_W-1:0] RATE_A_END_RST     = 16'd3277;
  localparam logic [REG_W-1:0] RADIUS_B_START_RST = 16'd1502;
  localparam logic [REG_W-1:0] RADIUS_B_END_RST   = 16'd28;
  localparam logic [REG_W-1:0] RATE_B_START_RST   = 16'hFF9E;
  localparam logic [REG_W-1:0] RATE_B_END_RST     = 16'hFFDF;

  localparam int NODE_OUT_W = 6;
  localparam int DIST_OUT_W = 35;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_INTERP = 5'b00100,
    S_DIST   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/som_train_and_classify_core.sv =====
// Top level: self-organizing map trainer and classifier with a shared multiplier.
//
// Usage:
// - Input channel (in_valid/in_ready): one Q1.15 feature per transaction, FEATURES
//   transactions per sample. action and progress count only on the last one.
// - Output channel (out_valid/out_ready): one transaction per sample, the winning
//   node and its squared distance, held in an output register until taken.
// - Config port: cfg_we/cfg_index/cfg_data writes a register.
// Sequence: a non-last feature is only stored. The last feature starts parameter
// interpolation, then the distance search and, in train mode, the weight update;
// both passes stream one codebook word per cycle through the single multiplier and
// the one read port of the codebook RAM.
// The result is posted after the search; the update runs behind it.
// Reset: a clearing pass writes zero to all NODES*FEATURES codebook words with
// in_ready low.
// Receiver stall: a last feature is not taken while a result is still unread.
module som_train_and_classify_core #(
  parameter int MAP_WIDTH  = stc_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = stc_pkg::MAP_HEIGHT_DEF,
  parameter int FEATURES   = stc_pkg::FEATURES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic signed [15:0]             feature,
  input  logic [15:0]                    progress,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stc_pkg::NODE_OUT_W-1:0] winner_node,
  output logic [stc_pkg::DIST_OUT_W-1:0] winner_distance,
  input  logic                           cfg_we,
  input  logic [stc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [stc_pkg::REG_W-1:0]      cfg_data
);
  import stc_pkg::*;

  localparam int NODES  = MAP_WIDTH * MAP_HEIGHT;
  localparam int DEPTH  = NODES * FEATURES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int XW     = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int YW     = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int DIST_W = 33 + ((FEATURES > 1) ? $clog2(FEATURES) : 0);
  localparam int CMP_W  = (XW + YW + 9 > 17) ? XW + YW + 9 : 17;

  state_t state;

  logic [REG_W-1:0] regs [NUM_REGS];

  // sample and latched per-sample controls
  logic signed [15:0] sample [FEATURES];
  logic [FW-1:0]      feature_count;
  logic               train_mode;
  logic [15:0]        prog;
  logic               last_item;

  // interpolated parameters
  logic [2:0]         istep;
  logic [15:0]        rad_a, rad_b;
  logic signed [15:0] rate_a, rate_b;

  // issue counters
  logic           issue_on;
  logic [AW-1:0]  c_addr;
  logic [FW-1:0]  c_f;
  logic [NW-1:0]  c_node;
  logic [XW-1:0]  c_x;
  logic [YW-1:0]  c_y;
  logic [AW-1:0]  clr_addr;

  // stage 1 (RAM data arrives)
  logic               p1_v, p1_en;
  logic [FW-1:0]      p1_f;
  logic [NW-1:0]      p1_node;
  logic [XW-1:0]      p1_x;
  logic [YW-1:0]      p1_y;
  logic [AW-1:0]      p1_addr;
  logic signed [15:0] p1_rate;

  // stage 2 (product registered)
  logic               p2_v, p2_en, p2_firstf, p2_lastf;
  logic [NW-1:0]      p2_node;
  logic [XW-1:0]      p2_x;
  logic [YW-1:0]      p2_y;
  logic [AW-1:0]      p2_addr;
  logic signed [15:0] p2_w;
  logic signed [33:0] prod;

  logic [DIST_W-1:0]  acc, best_d;
  logic [NW-1:0]      best_node;
  logic [XW-1:0]      best_x;
  logic [YW-1:0]      best_y;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata, ram_rdata;

  stc_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_codebook (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (c_addr),
    .rdata (ram_rdata)
  );

  assign last_item = (feature_count == FW'(FEATURES - 1));
  assign in_ready  = (state == S_IDLE) && !(out_valid && last_item);

  // interpolation operands, pair k = registers 2k and 2k+1
  logic signed [16:0] st17 [4];
  logic signed [16:0] en17 [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k == 1 || k == 3) begin
        st17[k] = {regs[2*k][15], regs[2*k]};
        en17[k] = {regs[2*k+1][15], regs[2*k+1]};
      end else begin
        st17[k] = {1'b0, regs[2*k]};
        en17[k] = {1'b0, regs[2*k+1]};
      end
    end
  end

  // shared multiplier operands
  logic signed [16:0] diff1, mul_a, mul_b;
  logic signed [15:0] s1;
  assign s1    = sample[p1_f];
  assign diff1 = 17'(s1) - 17'(signed'(ram_rdata));

  always_comb begin
    unique case (state)
      S_INTERP: begin
        mul_a = {1'b0, prog};
        mul_b = en17[istep[1:0]] - st17[istep[1:0]];
      end
      S_UPDATE: begin
        mul_a = diff1;
        mul_b = 17'(p1_rate);
      end
      default: begin
        mul_a = diff1;
        mul_b = diff1;
      end
    endcase
  end

  // interpolation result for pair istep-1
  logic [1:0]         ik;
  logic signed [17:0] ires;
  assign ik   = 2'(istep - 3'd1);
  assign ires = 18'(st17[ik]) + prod[33:16];

  // neighborhood of the node being issued
  logic [XW-1:0]    dx;
  logic [YW-1:0]    dy;
  logic [CMP_W-1:0] gd;
  assign dx = (c_x >= best_x) ? c_x - best_x : best_x - c_x;
  assign dy = (c_y >= best_y) ? c_y - best_y : best_y - c_y;
  assign gd = (CMP_W'(dx) + CMP_W'(dy)) << 8;

  // distance accumulate
  logic [DIST_W-1:0] dsum;
  assign dsum = (p2_firstf ? '0 : acc) + DIST_W'(prod[31:0]);

  // weight update with rounding and saturation
  logic signed [34:0] rnd;
  logic signed [20:0] nw;
  logic signed [15:0] nw_sat;
  assign rnd = 35'(prod) + 35'sd16384;
  assign nw  = 21'(p2_w) + 21'(signed'(rnd[34:15]));
  always_comb begin
    if (nw > 21'sd32767) nw_sat = 16'sh7FFF;
    else if (nw < -21'sd32768) nw_sat = 16'sh8000;
    else nw_sat = nw[15:0];
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_UPDATE) && p2_v && p2_en;
      ram_waddr = p2_addr;
      ram_wdata = nw_sat;
    end
  end

  logic last_issue, drained;
  assign last_issue = (c_node == NW'(NODES - 1)) && (c_f == FW'(FEATURES - 1));
  assign drained    = !issue_on && !p1_v && !p2_v;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_RADIUS_A_START] <= RADIUS_A_START_RST;
      regs[REG_RADIUS_A_END]   <= RADIUS_A_END_RST;
      regs[REG_RATE_A_START]   <= RATE_A_START_RST;
      regs[REG_RATE_A_END]     <= RATE_A_END_RST;
      regs[REG_RADIUS_B_START] <= RADIUS_B_START_RST;
      regs[REG_RADIUS_B_END]   <= RADIUS_B_END_RST;
      regs[REG_RATE_B_START]   <= RATE_B_START_RST;
      regs[REG_RATE_B_END]     <= RATE_B_END_RST;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample[feature_count] <= feature;
      if (last_item) begin
        train_mode <= !action;
        prog       <= progress;
      end
    end
    prod <= mul_a * mul_b;
    if (state == S_INTERP && istep != 3'd0) begin
      case (ik)
        2'd0:    rad_a  <= ires[15:0];
        2'd1:    rate_a <= ires[15:0];
        2'd2:    rad_b  <= ires[15:0];
        default: rate_b <= ires[15:0];
      endcase
    end
    // stage 1
    p1_f    <= c_f;
    p1_node <= c_node;
    p1_x    <= c_x;
    p1_y    <= c_y;
    p1_addr <= c_addr;
    p1_en   <= (gd <= CMP_W'(rad_a)) || (gd <= CMP_W'(rad_b));
    p1_rate <= (gd <= CMP_W'(rad_a)) ? rate_a : rate_b;
    // stage 2
    p2_firstf <= (p1_f == '0);
    p2_lastf  <= (p1_f == FW'(FEATURES - 1));
    p2_node   <= p1_node;
    p2_x      <= p1_x;
    p2_y      <= p1_y;
    p2_addr   <= p1_addr;
    p2_en     <= p1_en;
    p2_w      <= signed'(ram_rdata);
    if (state == S_DIST && p2_v) begin
      acc <= dsum;
      if (p2_lastf && (p2_node == '0 || dsum < best_d)) begin
        best_d    <= dsum;
        best_node <= p2_node;
        best_x    <= p2_x;
        best_y    <= p2_y;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      feature_count <= '0;
      istep         <= '0;
      issue_on      <= 1'b0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      out_valid     <= 1'b0;
      c_addr        <= '0;
      c_f           <= '0;
      c_node        <= '0;
      c_x           <= '0;
      c_y           <= '0;
    end else begin
      p1_v <= issue_on;
      p2_v <= p1_v;
      if (out_valid && out_ready) out_valid <= 1'b0;

      if (issue_on) begin
        if (last_issue) issue_on <= 1'b0;
        c_addr <= c_addr + AW'(1);
        if (c_f == FW'(FEATURES - 1)) begin
          c_f    <= '0;
          c_node <= c_node + NW'(1);
          if (c_x == XW'(MAP_WIDTH - 1)) begin
            c_x <= '0;
            c_y <= c_y + YW'(1);
          end else begin
            c_x <= c_x + XW'(1);
          end
        end else begin
          c_f <= c_f + FW'(1);
        end
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (last_item) begin
              feature_count <= '0;
              istep         <= '0;
              state         <= S_INTERP;
            end else begin
              feature_count <= feature_count + FW'(1);
            end
          end
        end
        S_INTERP: begin
          istep <= istep + 3'd1;
          if (istep == 3'd4) begin
            state    <= S_DIST;
            issue_on <= 1'b1;
            c_addr   <= '0;
            c_f      <= '0;
            c_node   <= '0;
            c_x      <= '0;
            c_y      <= '0;
          end
        end
        S_DIST: begin
          if (drained) begin
            out_valid       <= 1'b1;
            winner_node     <= NODE_OUT_W'(best_node);
            winner_distance <= DIST_OUT_W'(best_d);
            if (train_mode) begin
              state    <= S_UPDATE;
              issue_on <= 1'b1;
              c_addr   <= '0;
              c_f      <= '0;
              c_node   <= '0;
              c_x      <= '0;
              c_y      <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_UPDATE: begin
          if (drained) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/stc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/stc_checker.sv =====
// Port-level checks of the map core, bound to the top level.
module stc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [stc_pkg::NODE_OUT_W-1:0] winner_node,
  input logic [stc_pkg::DIST_OUT_W-1:0] winner_distance
);

  // result held until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped without transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(winner_node) && $stable(winner_distance))
    else $error("result changed while stalled");

  // codebook clearing pass keeps input closed right after reset
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during clearing pass");

  // a result only appears after the search, while input was closed
  a_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result posted without a search");

endmodule

bind som_train_and_classify_core stc_checker u_stc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .winner_node     (winner_node),
  .winner_distance (winner_distance)
);

// ===== tb/sv/som_train_and_classify_core_test.sv =====
// Self-checking testbench of the self-organizing map train/classify core.
`timescale 1ns / 100ps

module som_train_and_classify_core_test;
  import stc_pkg::*;

  localparam int MW        = MAP_WIDTH_DEF;
  localparam int MH        = MAP_HEIGHT_DEF;
  localparam int NFEAT     = FEATURES_DEF;
  localparam int NODES     = MW * MH;
  localparam int SETTLE    = NODES * NFEAT + 64;  // update pass trails the result
  localparam int WDOG_MAX  = 20000;

  typedef struct {
    logic [NODE_OUT_W-1:0] node;
    logic [DIST_OUT_W-1:0] dist_sq;
  } winner_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic action = 0;
  logic signed [15:0] feature = '0;
  logic [15:0] progress = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [NODE_OUT_W-1:0] winner_node;
  logic [DIST_OUT_W-1:0] winner_distance;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  // Predictor state
  logic [REG_W-1:0] som_regs [NUM_REGS];
  int               weights [NODES*NFEAT];
  int               sample_buf [NFEAT];
  int               feat_cnt;
  winner_t          winners_pending[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_trained = 0;
  bit  steady = 0;  // no idling on either side when set
  int  wdog = 0;

  always #2 clk = ~clk;

  som_train_and_classify_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .feature(feature), .progress(progress),
    .out_valid(out_valid), .out_ready(out_ready),
    .winner_node(winner_node), .winner_distance(winner_distance),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 34);
  endfunction

  function automatic longint lerp(longint s, longint e, logic [15:0] p);
    longint t;
    t = longint'(p) * (e - s);
    return s + (t >>> 16);
  endfunction

  // Winner search and, when training, the neighborhood update.
  task automatic som_absorb(logic act, logic [15:0] prog);
    longint  best_d, d, diff, rad_a, rad_b, rate_a, rate_b, rate, gd, nw;
    int      best, dx, dy;
    winner_t w;
    best = 0;
    best_d = 0;
    for (int i = 0; i < NODES; i++) begin
      d = 0;
      for (int j = 0; j < NFEAT; j++) begin
        diff = longint'(sample_buf[j]) - weights[i*NFEAT+j];
        d += diff * diff;
      end
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    if (act == 1'b0) begin
      n_trained++;
      rad_a  = lerp(som_regs[REG_RADIUS_A_START], som_regs[REG_RADIUS_A_END], prog);
      rad_b  = lerp(som_regs[REG_RADIUS_B_START], som_regs[REG_RADIUS_B_END], prog);
      rate_a = lerp($signed(som_regs[REG_RATE_A_START]), $signed(som_regs[REG_RATE_A_END]),
                    prog);
      rate_b = lerp($signed(som_regs[REG_RATE_B_START]), $signed(som_regs[REG_RATE_B_END]),
                    prog);
      for (int i = 0; i < NODES; i++) begin
        dx = (i % MW) - (best % MW);
        dy = (i / MW) - (best / MW);
        gd = ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy)) * 256;
        if (gd <= rad_a) rate = rate_a;
        else if (gd <= rad_b) rate = rate_b;
        else continue;
        for (int j = 0; j < NFEAT; j++) begin
          diff = longint'(sample_buf[j]) - weights[i*NFEAT+j];
          nw = weights[i*NFEAT+j] + ((rate * diff + 16384) >>> 15);
          if (nw > 32767) nw = 32767;
          if (nw < -32768) nw = -32768;
          weights[i*NFEAT+j] = int'(nw);
        end
      end
    end
    w.node    = best[NODE_OUT_W-1:0];
    w.dist_sq = best_d[DIST_OUT_W-1:0];
    winners_pending = {winners_pending, w};
  endtask

  task automatic som_accept(logic act, logic signed [15:0] f, logic [15:0] prog);
    sample_buf[feat_cnt] = f;
    n_items++;
    if (feat_cnt + 1 < NFEAT) begin
      feat_cnt++;
    end else begin
      feat_cnt = 0;
      som_absorb(act, prog);
    end
  endtask

  // Drive one feature; returns at the edge that accepted it, valid still high.
  task automatic send_feature(logic act, logic signed [15:0] f, logic [15:0] prog);
    bit rdy;
    if (take_break()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    feature  <= f;
    progress <= prog;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    som_accept(act, f, prog);
  endtask

  function automatic logic [15:0] rand_feature();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic act, logic [15:0] prog, bit edgy);
    for (int j = 0; j < NFEAT; j++) begin
      if (j == NFEAT - 1)
        send_feature(act, edgy ? rand_feature() : 16'($urandom), prog);
      else
        send_feature(1'($urandom), edgy ? rand_feature() : 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic send_const_sample(logic act, logic signed [15:0] f, logic [15:0] prog);
    for (int j = 0; j < NFEAT; j++) send_feature(act, f, prog);
  endtask

  // Drain results and let the trailing update pass finish.
  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (winners_pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    som_regs[idx] = val;
  endtask

  task automatic load_regs(logic [15:0] ra0, logic [15:0] ra1, logic [15:0] qa0,
                           logic [15:0] qa1, logic [15:0] rb0, logic [15:0] rb1,
                           logic [15:0] qb0, logic [15:0] qb1);
    reg_write(REG_RADIUS_A_START, ra0);
    reg_write(REG_RADIUS_A_END,   ra1);
    reg_write(REG_RATE_A_START,   qa0);
    reg_write(REG_RATE_A_END,     qa1);
    reg_write(REG_RADIUS_B_START, rb0);
    reg_write(REG_RADIUS_B_END,   rb1);
    reg_write(REG_RATE_B_START,   qb0);
    reg_write(REG_RATE_B_END,     qb1);
  endtask

  // Zero codebook: every node ties, lowest index must win.
  task automatic test_reset_ties();
    send_const_sample(1'b1, 16'sd0, 16'd0);
    send_const_sample(1'b1, 16'sh7fff, 16'hffff);
    send_const_sample(1'b0, 16'sh8000, 16'd0);
    drain();
  endtask

  task automatic test_field_extremes();
    send_const_sample(1'b0, 16'sh7fff, 16'hffff);
    send_sample(1'b0, 16'h8000, 1);
    send_sample(1'b1, 16'h0001, 1);
    drain();
  endtask

  // Saturating rates, zero and full radii, then the defaults back.
  task automatic test_config_extremes();
    load_regs(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff,
              16'h8000, 16'h8000);
    send_const_sample(1'b0, 16'sh8000, 16'd0);
    send_sample(1'b0, 16'hffff, 1);
    drain();
    load_regs(16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h0000, 16'h0300,
              16'h7fff, 16'h8000);
    send_sample(1'b0, 16'h0000, 1);
    send_sample(1'b0, 16'h8000, 1);
    send_sample(1'b0, 16'hffff, 1);
    drain();
    load_regs(RADIUS_A_START_RST, RADIUS_A_END_RST, RATE_A_START_RST, RATE_A_END_RST,
              RADIUS_B_START_RST, RADIUS_B_END_RST, RATE_B_START_RST, RATE_B_END_RST);
  endtask

  task automatic test_random_training();
    for (int ph = 0; ph < 4; ph++) begin
      steady = (ph == 2);
      if (ph == 1)
        load_regs(16'($urandom_range(2048)), 16'($urandom_range(2048)),
                  16'($urandom_range(32767)), 16'($urandom_range(32767)),
                  16'($urandom_range(3072)), 16'($urandom_range(3072)),
                  16'($urandom), 16'($urandom));
      if (ph == 3)
        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      for (int s = 0; s < 20; s++) begin
        logic [15:0] prog;
        case ($urandom_range(7))
          0: prog = 16'h0000;
          1: prog = 16'hffff;
          default: prog = 16'($urandom);
        endcase
        send_sample(1'($urandom_range(99) < 25), prog, $urandom_range(3) == 0);
      end
      drain();
    end
    steady = 0;
  endtask

  // Result side: sample before the edge, decide ready after it.
  initial begin
    bit v, r;
    winner_t got, want;
    forever begin
      @(negedge clk);
      v = out_valid;
      r = out_ready;
      got.node    = winner_node;
      got.dist_sq = winner_distance;
      @(posedge clk);
      if (v && r) begin
        n_results++;
        if (winners_pending.size() == 0) begin
          errors++;
          $display("%0t unexpected result: node %0d dist %0d", $time, got.node,
                   got.dist_sq);
        end else begin
          want = winners_pending.pop_front();
          if (got.node !== want.node) begin
            errors++;
            $display("%0t winner_node expected %0d actual %0d", $time, want.node, got.node);
          end
          if (got.dist_sq !== want.dist_sq) begin
            errors++;
            $display("%0t winner_distance expected %0d actual %0d",
                     $time, want.dist_sq, got.dist_sq);
          end
        end
      end
      out_ready <= !rst && !take_break();
    end
  end

  // Watchdog: too long without any transaction.
  initial begin
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("%0t timeout, %0d results outstanding", $time, winners_pending.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    som_regs[REG_RADIUS_A_START] = RADIUS_A_START_RST;
    som_regs[REG_RADIUS_A_END]   = RADIUS_A_END_RST;
    som_regs[REG_RATE_A_START]   = RATE_A_START_RST;
    som_regs[REG_RATE_A_END]     = RATE_A_END_RST;
    som_regs[REG_RADIUS_B_START] = RADIUS_B_START_RST;
    som_regs[REG_RADIUS_B_END]   = RADIUS_B_END_RST;
    som_regs[REG_RATE_B_START]   = RATE_B_START_RST;
    som_regs[REG_RATE_B_END]     = RATE_B_END_RST;
    foreach (weights[k]) weights[k] = 0;
    feat_cnt = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_ties();
    test_field_extremes();
    test_config_extremes();
    test_random_training();
    $display("Covered %0d features, %0d winners checked, %0d training updates,",
             n_items, n_results, n_trained);
    $display("extreme and random radius/rate settings, with and without stalls.");
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
